### rtl/core/rpn_pkg.sv
package rpn_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_DIV_ZERO  = 3'd3,
    STAT_BAD_OP    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_cmd_t;

  typedef struct packed {
    logic     start;
    alu_cmd_t cmd;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

endpackage

### rtl/core/rpn_alu.sv
module rpn_alu (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::alu_req_t req,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output rpn_pkg::alu_rsp_t rsp
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDSUB,
    S_ABS_A,
    S_ABS_B,
    S_MUL,
    S_DCHK,
    S_DIV,
    S_ROUND,
    S_SIGN
  } state_t;

  state_t      state;
  alu_cmd_t    cmd;
  logic        neg;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] acc;
  logic [31:0] lo;
  logic [31:0] mag;
  logic [4:0]  cnt;

  // the one shared adder
  logic [33:0] add_x;
  logic [33:0] add_y;
  logic        add_cin;
  logic [33:0] sum;
  logic        ge;
  logic        inc;
  logic        big;
  logic        over;
  logic        is_sub;

  assign is_sub = (cmd == ALU_SUB);
  assign inc    = neg & (|lo[15:0]);

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_ADDSUB: begin
        add_x   = {{2{ra[31]}}, ra};
        add_y   = is_sub ? ~{{2{rb[31]}}, rb} : {{2{rb[31]}}, rb};
        add_cin = is_sub;
      end
      S_ABS_A: begin
        add_y   = ra[31] ? ~{2'b00, ra} : {2'b00, ra};
        add_cin = ra[31];
      end
      S_ABS_B: begin
        add_y   = rb[31] ? ~{2'b00, rb} : {2'b00, rb};
        add_cin = rb[31];
      end
      S_MUL: begin
        add_x = {2'b00, acc};
        add_y = lo[0] ? {2'b00, ra} : '0;
      end
      S_DCHK: begin
        add_x   = {17'd0, ra[31:15]};
        add_y   = ~{2'b00, rb};
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_x   = {1'b0, acc, lo[31]};
        add_y   = ~{2'b00, rb};
        add_cin = 1'b1;
      end
      S_ROUND: begin
        add_x   = {2'b00, acc[15:0], lo[31:16]};
        add_cin = inc;
      end
      S_SIGN: begin
        add_y   = neg ? ~{2'b00, mag} : {2'b00, mag};
        add_cin = neg;
      end
      default: begin
      end
    endcase
  end

  assign sum  = add_x + add_y + 34'(add_cin);
  assign ge   = ~sum[33];
  assign big  = |acc[31:16];
  assign over = big | sum[32] | (neg ? (sum[31] & (|sum[30:0])) : sum[31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            ra    <= a;
            rb    <= b;
            cmd   <= req.cmd;
            neg   <= a[31] ^ b[31];
            state <= (req.cmd == ALU_ADD || req.cmd == ALU_SUB) ? S_ADDSUB : S_ABS_A;
          end
        end
        S_ADDSUB: begin
          rsp.result <= (sum[32] != sum[31]) ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
          rsp.done   <= 1'b1;
          state      <= S_IDLE;
        end
        S_ABS_A: begin
          ra    <= sum[31:0];
          state <= S_ABS_B;
        end
        S_ABS_B: begin
          rb    <= sum[31:0];
          acc   <= '0;
          lo    <= sum[31:0];
          cnt   <= 5'd31;
          state <= (cmd == ALU_MUL) ? S_MUL : S_DCHK;
        end
        S_MUL: begin
          acc <= sum[32:1];
          lo  <= {sum[0], lo[31:1]};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_ROUND;
          end
        end
        S_DCHK: begin
          // quotient would reach 2^31: clamp and skip the iterations
          if (ge) begin
            mag   <= neg ? Q_MIN : Q_MAX;
            state <= S_SIGN;
          end else begin
            acc   <= {15'd0, ra[31:15]};
            lo    <= {ra[14:0], 17'd0};
            cnt   <= 5'd30;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          acc <= ge ? sum[31:0] : {acc[30:0], lo[31]};
          lo  <= {lo[30:0], ge};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            mag   <= {1'b0, lo[29:0], ge};
            state <= S_SIGN;
          end
        end
        S_ROUND: begin
          mag   <= over ? (neg ? Q_MIN : Q_MAX) : sum[31:0];
          state <= S_SIGN;
        end
        S_SIGN: begin
          rsp.result <= sum[31:0];
          rsp.done   <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/rpn_stack_calculator.sv
// Channel  | Direction | Signals                          | Contents (low bit up)
// s_axis   | in        | tvalid tready tdata[31:0] tuser  | tdata: number_value;
//          |           |                                  | tuser: operation
// m_axis   | out       | tvalid tready tdata[39:0] tuser  | tdata: top_value, stack_depth;
//          |           |                                  | tuser: status
//
// One item at a time. Push and bad opcodes go from accept straight to FINISH; pop, add,
// subtract, multiply and divide first pop their operands. Multiply and divide make 32 or
// 31 passes through the shared adder in rpn_alu; divide skips them when the quotient
// clamps early. Reset is synchronous and empties the stack; entries are not cleared.
// A finished beat waits in the output register while the next item is taken; a new
// result holds in FINISH until that register is free.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] number_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] top_value, [39:32] stack_depth
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import rpn_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    T_IDLE,
    T_POP_B,
    T_LOAD_B,
    T_CHECK_B,
    T_POP_A,
    T_LOAD_A,
    T_START,
    T_RUN,
    T_FINISH
  } state_t;

  state_t      state;
  opcode_t     op;
  opcode_t     op_in;
  logic        under;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] res_top;
  status_t     res_status;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_dec;
  logic        s_acc;

  // operand stack
  logic [31:0]   stack_mem [STACK_DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign s_axis_tready = (state == T_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign op_in         = opcode_t'(s_axis_tuser);
  assign sp_dec        = sp - SPW'(1);
  assign rd_addr       = sp_dec[AW-1:0];
  assign wr_addr       = sp[AW-1:0];

  // Write the pushed number on accept, or the ALU result when it lands.
  assign wr_en   = (s_acc && op_in == OP_PUSH && sp != SP_FULL) ||
                   (state == T_RUN && alu_rsp.done);
  assign wr_data = (state == T_IDLE) ? s_axis_tdata : alu_rsp.result;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_comb begin
    alu_req.start = (state == T_START);
    unique case (op)
      OP_ADD:  alu_req.cmd = ALU_ADD;
      OP_SUB:  alu_req.cmd = ALU_SUB;
      OP_MUL:  alu_req.cmd = ALU_MUL;
      default: alu_req.cmd = ALU_DIV;
    endcase
  end

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (opa),
    .b   (opb),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      sp            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop the beat once taken, unless FINISH loads the next one
      if (m_axis_tvalid && m_axis_tready && state != T_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (s_acc) begin
            op    <= op_in;
            under <= 1'b0;
            unique case (op_in)
              OP_PUSH: begin
                // drop the value when the stack is full
                if (sp != SP_FULL) begin
                  sp         <= sp + SPW'(1);
                  res_top    <= s_axis_tdata;
                  res_status <= STAT_OK;
                end else begin
                  res_top    <= '0;
                  res_status <= STAT_OVERFLOW;
                end
                state <= T_FINISH;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP: begin
                res_top    <= '0;
                res_status <= STAT_OK;
                state      <= T_POP_B;
              end
              default: begin
                res_top    <= '0;
                res_status <= STAT_BAD_OP;
                state      <= T_FINISH;
              end
            endcase
          end
        end
        T_POP_B: begin
          // an empty stack reads as zero
          if (sp == '0) begin
            under <= 1'b1;
            opb   <= '0;
            state <= T_CHECK_B;
          end else begin
            sp    <= sp_dec;
            state <= T_LOAD_B;
          end
        end
        T_LOAD_B: begin
          opb   <= rd_data;
          state <= T_CHECK_B;
        end
        T_CHECK_B: begin
          priority if (op == OP_POP) begin
            res_top <= opb;
            state   <= T_FINISH;
          end else if (op == OP_DIV && opb == '0) begin
            // divisor consumed, left operand stays
            res_status <= STAT_DIV_ZERO;
            state      <= T_FINISH;
          end else begin
            state <= T_POP_A;
          end
        end
        T_POP_A: begin
          if (sp == '0) begin
            under <= 1'b1;
            opa   <= '0;
            state <= T_START;
          end else begin
            sp    <= sp_dec;
            state <= T_LOAD_A;
          end
        end
        T_LOAD_A: begin
          opa   <= rd_data;
          state <= T_START;
        end
        T_START: begin
          state <= T_RUN;
        end
        T_RUN: begin
          // the operands were popped or the stack was empty, so the push always fits
          if (alu_rsp.done) begin
            sp      <= sp + SPW'(1);
            res_top <= alu_rsp.result;
            state   <= T_FINISH;
          end
        end
        T_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {8'(sp), res_top};
            m_axis_tuser  <= under ? STAT_UNDERFLOW : res_status;
            m_axis_tvalid <= 1'b1;
            state         <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/rpn_checker.sv
module rpn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import rpn_pkg::*;

  // one item in flight: no second beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on the cycle after an accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STAT_OVERFLOW) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("dropped push reports a nonzero value");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == STAT_DIV_ZERO || m_axis_tuser == STAT_BAD_OP))
      |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("error beat reports a nonzero value");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat present right after reset");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

### verif/rpn_stack_calculator_test.sv
module rpn_stack_calculator_test;
  import rpn_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int STACK_LIMIT    = 128;
  localparam int HOLD_CYCLES    = 400;     // long receiver hold-off, enough to fill the block
  localparam int END_TAIL       = 80;      // longer than the slowest op (multiply)
  localparam int TIMEOUT_CYCLES = 1000000;

  // Opcodes the package leaves unnamed; both must come back flagged.
  localparam logic [2:0] OP_RESERVED_A = 3'd6;
  localparam logic [2:0] OP_RESERVED_B = 3'd7;

  typedef struct {
    logic [31:0] top;
    status_t     status;
    logic [7:0]  depth;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;     // [31:0] number_value
  logic [2:0]  s_axis_tuser = '0;     // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // [31:0] top_value, [39:32] stack_depth
  logic [2:0]  m_axis_tuser;          // [2:0] status

  // Shadow copy of the operand stack, advanced once per accepted beat.
  logic [31:0]  calc_stack [STACK_LIMIT];
  int unsigned  calc_depth = 0;
  bit           calc_underflow;
  calc_result_t pending_results [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;

  rpn_stack_calculator #(.STACK_DEPTH(STACK_LIMIT)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Pop one operand; an empty stack reads as zero and marks underflow.
  function automatic longint pop_operand();
    if (calc_depth == 0) begin
      calc_underflow = 1'b1;
      return 0;
    end
    calc_depth--;
    return longint'($signed(calc_stack[calc_depth]));
  endfunction

  // Clamp to the Q16.16 range; saturation is silent.
  function automatic logic [31:0] clamp_q(longint v);
    if (v > 64'sd2147483647)
      return Q_MAX;
    if (v < -64'sd2147483648)
      return Q_MIN;
    return v[31:0];
  endfunction

  // Apply one token to the shadow stack and return the beat it should produce.
  function automatic calc_result_t apply_token(logic [2:0] op, logic [31:0] value);
    calc_result_t r;
    longint       lhs;
    longint       rhs;
    r.top          = '0;
    r.status       = STAT_OK;
    calc_underflow = 1'b0;
    case (op)
      OP_PUSH: begin
        if (calc_depth < STACK_LIMIT) begin
          calc_stack[calc_depth] = value;
          calc_depth++;
          r.top = value;
        end else begin
          r.status = STAT_OVERFLOW;
        end
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        // Right operand comes off first.
        rhs = pop_operand();
        lhs = pop_operand();
        if (op == OP_ADD)
          r.top = clamp_q(lhs + rhs);
        else if (op == OP_SUB)
          r.top = clamp_q(lhs - rhs);
        else
          r.top = clamp_q((lhs * rhs) >>> 16);   // arithmetic shift floors
        calc_stack[calc_depth] = r.top;
        calc_depth++;
      end
      OP_DIV: begin
        rhs = pop_operand();
        if (rhs == 0) begin
          // Drop the divisor, keep the dividend, push nothing.
          r.status = STAT_DIV_ZERO;
        end else begin
          lhs   = pop_operand();
          r.top = clamp_q((lhs * 64'sd65536) / rhs);   // truncates toward zero
          calc_stack[calc_depth] = r.top;
          calc_depth++;
        end
      end
      OP_POP: begin
        rhs   = pop_operand();
        r.top = rhs[31:0];
      end
      default: r.status = STAT_BAD_OP;
    endcase
    if (calc_underflow)
      r.status = STAT_UNDERFLOW;
    r.depth = 8'(calc_depth);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: compare every accepted output beat with the oldest
  // prediction. Sampling at the edge sees the values from before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_beat
    calc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $error("result beat with no prediction pending: tdata %h tuser %0d",
               m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.top) begin
          error_count++;
          $error("top_value: expected %h, got %h", want.top, m_axis_tdata[31:0]);
        end
        if (m_axis_tuser !== want.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        end
        if (m_axis_tdata[39:32] !== want.depth) begin
          error_count++;
          $error("stack_depth: expected %0d, got %0d", want.depth, m_axis_tdata[39:32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or a long counted hold-off when the test asks
  // for one by bumping hold_trigger.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen     <= hold_trigger;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offer one token, hold it until accepted, then predict its result.
  // Called at a rising edge; tvalid is lowered only ahead of a real gap.
  task automatic send_token(logic [2:0] op, logic [31:0] value);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(apply_token(op, value));
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Mix corner values, small Q16.16 numbers (keep multiply/divide in range)
  // and raw 32-bit noise so every bit of number_value toggles.
  function automatic logic [31:0] pick_number();
    logic [31:0] corner [7];
    int unsigned roll;
    corner = '{Q_MAX, Q_MIN, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000, 32'hFFFF_0000};
    roll   = $urandom_range(0, 99);
    if (roll < 12)
      return corner[$urandom_range(0, 6)];
    if (roll < 55)
      return {16'($signed($urandom_range(0, 600)) - 16'sd300), 16'($urandom)};
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases on a fresh (empty) stack.
  task automatic test_directed();
    send_token(OP_POP, $urandom);                 // pop from empty: underflow, reads zero
    send_token(OP_ADD, $urandom);                 // both operands missing, still pushes 0
    send_token(OP_DIV, $urandom);                 // divisor is that zero: divide by zero
    send_token(OP_DIV, $urandom);                 // empty divisor: underflow wins
    send_token(OP_PUSH, Q_MAX);
    send_token(OP_PUSH, Q_MAX);
    send_token(OP_ADD, $urandom);                 // saturate high
    send_token(OP_PUSH, Q_MIN);
    send_token(OP_SUB, $urandom);                 // max minus min: saturate high
    send_token(OP_PUSH, Q_MIN);
    send_token(OP_MUL, $urandom);                 // saturate low
    send_token(OP_PUSH, 32'h0);
    send_token(OP_DIV, $urandom);                 // divide by zero keeps the dividend
    send_token(OP_PUSH, 32'hFFFF_FFFF);
    send_token(OP_DIV, $urandom);                 // min / tiny negative: saturate high
    send_token(OP_PUSH, 32'hFFFF_FFFF);
    send_token(OP_MUL, $urandom);                 // negative product rounds toward -inf
    send_token(OP_PUSH, 32'h0001_8000);
    send_token(OP_SUB, $urandom);
    send_token(OP_RESERVED_A, $urandom);
    send_token(OP_RESERVED_B, $urandom);
    send_token(OP_POP, $urandom);
    send_token(OP_PUSH, 32'h0003_0000);
    send_token(OP_DIV, $urandom);                 // dividend missing: underflow, pushes 0
    send_token(OP_POP, $urandom);
  endtask

  // Fill the stack to the top, overflow it, then empty it past the bottom.
  task automatic test_stack_limits();
    while (calc_depth != 0) send_token(OP_POP, $urandom);
    repeat (STACK_LIMIT) send_token(OP_PUSH, pick_number());
    send_token(OP_PUSH, pick_number());           // full: dropped
    send_token(OP_PUSH, pick_number());
    send_token(OP_MUL, $urandom);                 // frees one slot
    send_token(OP_PUSH, pick_number());
    send_token(OP_PUSH, pick_number());           // full again
    while (calc_depth != 0) send_token(OP_POP, $urandom);
    send_token(OP_POP, $urandom);
  endtask

  // Stall the output for a long stretch while input keeps coming, so the
  // block backs up and drops tready on the input side.
  task automatic test_backpressure();
    hold_trigger <= hold_trigger + 1;
    repeat (16) send_token(3'($urandom_range(0, 5)), pick_number());
  endtask

  // Pause the sender until everything predicted has come out, then resume.
  task automatic test_drain_pause();
    repeat (10) send_token(3'($urandom_range(0, 5)), pick_number());
    drain_results();
    repeat (10) send_token(3'($urandom_range(0, 5)), pick_number());
  endtask

  // Mostly well-formed RPN streams with a push bias that drifts every 64
  // tokens, so the stack depth wanders from empty to full; a few reserved
  // opcodes thrown in as noise.
  task automatic test_random_stream(int unsigned count);
    int unsigned push_pct;
    int unsigned roll;
    logic [2:0]  op;
    push_pct = 40;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0)
        push_pct = $urandom_range(25, 75);
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = ($urandom_range(0, 1) != 0) ? OP_RESERVED_A : OP_RESERVED_B;
      else if (roll < push_pct || (calc_depth < 2 && roll < 85))
        op = OP_PUSH;
      else
        op = 3'($urandom_range(1, 5));
      send_token(op, pick_number());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(38, 79);
    test_directed();
    test_stack_limits();
    test_random_stream(520);

    set_idling(79, 38);
    test_drain_pause();
    test_random_stream(520);

    set_idling(0, 0);
    test_backpressure();
    test_random_stream(480);

    drain_results();
    repeat (END_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
